/* design/fktr_pkg.sv */
package fktr_pkg;

	// ranked list depth and derived widths
	localparam int RECORD_DEPTH = 8;
	localparam int LIST_COUNT = 4;
	localparam int IDX_W = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
	localparam int RNK_W = $clog2(RECORD_DEPTH + 1);

	// request codes
	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// the four ranking orders
	typedef enum logic [1:0] {
		LIST_FASTEST = 2'd0,
		LIST_SLOWEST = 2'd1,
		LIST_FACTORS = 2'd2,
		LIST_UNIQUE  = 2'd3
	} list_kind_t;

	// one stored record
	typedef struct packed {
		logic [63:0] number;
		logic [31:0] calc_time;
		logic [5:0]  factor_count;
		logic [3:0]  unique_count;
	} entry_t;

	// entry value before anything was written into a slot
	function automatic entry_t reset_entry(list_kind_t kind);
		entry_t e;
		e = '0;
		if (kind == LIST_FASTEST) begin
			e.calc_time = '1;
		end
		return e;
	endfunction

	// strict win of a new record over a stored entry
	function automatic logic beats(list_kind_t kind, entry_t cur, entry_t rec);
		logic win;
		case (kind)
			LIST_FASTEST: win = rec.calc_time < cur.calc_time;
			LIST_SLOWEST: win = rec.calc_time > cur.calc_time;
			LIST_FACTORS: win = (rec.factor_count > cur.factor_count) ||
				((rec.factor_count == cur.factor_count) &&
				(rec.unique_count > cur.unique_count));
			default: win = (rec.unique_count > cur.unique_count) ||
				((rec.unique_count == cur.unique_count) &&
				(rec.factor_count > cur.factor_count));
		endcase
		return win;
	endfunction

endpackage

/* design/fktr_cell.sv */
module fktr_cell import fktr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  list_kind_t kind,
	input  logic       ins_en,
	input  entry_t     rec,
	input  entry_t     prev_entry,
	input  logic       placed_in,
	output entry_t     entry,
	output logic       placed_out
);

	logic   valid_q;
	entry_t data_q;
	logic   win;

	// slot content, reset value until first write
	assign entry = valid_q ? data_q : reset_entry(kind);

	// compare against the incoming record and pass placement down the row
	assign win = beats(kind, entry, rec);
	assign placed_out = placed_in | win;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins_en && placed_out) begin
			valid_q <= 1'b1;
		end
	end

	// shift in neighbor entry, or take the record at the first winning slot
	always_ff @(posedge clk) begin
		if (ins_en) begin
			if (placed_in) begin
				data_q <= prev_entry;
			end else if (win) begin
				data_q <= rec;
			end
		end
	end

endmodule

/* design/fktr_list.sv */
module fktr_list import fktr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  list_kind_t       kind,
	input  logic             ins_en,
	input  entry_t           rec,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [RNK_W-1:0] rank,
	output entry_t           rd_entry
);

	logic   placed_w [0:RECORD_DEPTH];
	entry_t entry_w  [RECORD_DEPTH];

	assign placed_w[0] = 1'b0;

	// row of insertion cells
	for (genvar i = 0; i < RECORD_DEPTH; i++) begin : g_cell
		entry_t prev_w;
		if (i == 0) begin : g_head
			assign prev_w = rec;
		end else begin : g_body
			assign prev_w = entry_w[i-1];
		end
		fktr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.kind       (kind),
			.ins_en     (ins_en),
			.rec        (rec),
			.prev_entry (prev_w),
			.placed_in  (placed_w[i]),
			.entry      (entry_w[i]),
			.placed_out (placed_w[i+1])
		);
	end

	// slot taken: first cell where placement starts
	always_comb begin
		rank = RNK_W'(RECORD_DEPTH);
		for (int i = RECORD_DEPTH - 1; i >= 0; i--) begin
			if (placed_w[i+1] && !placed_w[i]) begin
				rank = RNK_W'(i);
			end
		end
	end

	// read port
	assign rd_entry = entry_w[rd_idx];

endmodule

/* design/four_way_top_k_record_tracker_top.sv */
// channel   ports                                         handshake
// ------    --------------------------------------------  -------------------------
// request   req_type number calc_time factor_count        start high, busy low
//           unique_count list_select rank_index
// result    fastest_rank slowest_rank most_factors_rank   done high for one cycle
//           most_unique_rank entry_* time_sum
//
// every transaction completes without stalling: the insertion cells compare and shift all
// slots of the four lists at once, and the result registers are loaded on the
// same edge, so done follows start in the next cycle and busy stays low.
// reset clears the slot valid flags and the running sum; no clearing pass.
// the receiver cannot stall; each result is held in the result registers until the next transaction.
module four_way_top_k_record_tracker_top import fktr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [63:0] number,
	input  logic [31:0] calc_time,
	input  logic [5:0]  factor_count,
	input  logic [3:0]  unique_count,
	input  logic [1:0]  list_select,
	input  logic [2:0]  rank_index,
	output logic        done,
	output logic [3:0]  fastest_rank,
	output logic [3:0]  slowest_rank,
	output logic [3:0]  most_factors_rank,
	output logic [3:0]  most_unique_rank,
	output logic [63:0] entry_number,
	output logic [31:0] entry_time,
	output logic [5:0]  entry_factor_count,
	output logic [3:0]  entry_unique_count,
	output logic [63:0] time_sum
);

	entry_t           rec;
	logic             accept;
	logic             ins_en;
	logic [IDX_W-1:0] rd_idx;
	logic             rd_in_range;
	logic [RNK_W-1:0] rank_w [LIST_COUNT];
	entry_t           rd_w   [LIST_COUNT];
	entry_t           rd_sel;
	logic [64:0]      sum_ext;
	logic [63:0]      sum_next;

	logic             done_q;
	logic [3:0]       rank_q [LIST_COUNT];
	entry_t           out_entry_q;
	logic [63:0]      sum_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign ins_en = accept && (req_type == REQ_RECORD);

	assign rec.number       = number;
	assign rec.calc_time    = calc_time;
	assign rec.factor_count = factor_count;
	assign rec.unique_count = unique_count;

	assign rd_idx      = IDX_W'(rank_index);
	assign rd_in_range = int'(rank_index) < RECORD_DEPTH;

	// four ranked lists
	for (genvar l = 0; l < LIST_COUNT; l++) begin : g_list
		fktr_list u_list (
			.clk      (clk),
			.arst_n   (arst_n),
			.kind     (list_kind_t'(2'(l))),
			.ins_en   (ins_en),
			.rec      (rec),
			.rd_idx   (rd_idx),
			.rank     (rank_w[l]),
			.rd_entry (rd_w[l])
		);
	end

	assign rd_sel = rd_w[list_select];

	// saturating running sum
	assign sum_ext  = {1'b0, sum_q} + {33'b0, calc_time};
	assign sum_next = sum_ext[64] ? '1 : sum_ext[63:0];

	// strobe and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			sum_q  <= '0;
		end else begin
			done_q <= accept;
			if (ins_en) begin
				sum_q <= sum_next;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_type == REQ_RECORD) begin
				for (int l = 0; l < LIST_COUNT; l++) begin
					rank_q[l] <= 4'(rank_w[l]);
				end
				out_entry_q <= '0;
			end else begin
				for (int l = 0; l < LIST_COUNT; l++) begin
					rank_q[l] <= 4'(RECORD_DEPTH);
				end
				out_entry_q <= rd_in_range ? rd_sel : '0;
			end
		end
	end

	assign done               = done_q;
	assign fastest_rank       = rank_q[LIST_FASTEST];
	assign slowest_rank       = rank_q[LIST_SLOWEST];
	assign most_factors_rank  = rank_q[LIST_FACTORS];
	assign most_unique_rank   = rank_q[LIST_UNIQUE];
	assign entry_number       = out_entry_q.number;
	assign entry_time         = out_entry_q.calc_time;
	assign entry_factor_count = out_entry_q.factor_count;
	assign entry_unique_count = out_entry_q.unique_count;
	assign time_sum           = sum_q;

`ifndef SYNTH
	// one result per transaction, in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> done) else $error("missing result strobe");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |=> !done) else $error("result strobe without transaction");
	// read results report no placement
	a_read_ranks: assert property (@(posedge clk) disable iff (!arst_n)
		(start && req_type == REQ_READ) |=>
		(fastest_rank == 4'(RECORD_DEPTH) && most_unique_rank == 4'(RECORD_DEPTH)))
		else $error("read result carries a rank");
	// running sum never decreases
	a_sum_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 time_sum >= $past(time_sum)) else $error("running sum decreased");
`endif

endmodule
